// File: rtl/aspr_pkg.sv
// Shared types and constants for the box push-out resolver.
// No dependencies; used by aabb_sphere_pushout_resolver_core, aspr_checker and tb_top.
package aspr_pkg;

  localparam int unsigned MaxBoxesDef   = 64;
  localparam int unsigned CoordWidthDef = 24;
  localparam int unsigned CountWidth    = 7;
  localparam int unsigned IndexWidth    = 6;
  localparam int unsigned RadiusWidth   = 16;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

endpackage

// File: rtl/aspr_cell.sv
// One cell of the box ring: holds a single box and its solid flag.
// Depends on no package items; instantiated by the resolver core.
module aspr_cell #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          shift_i,
  input  logic                          wr_solid_i,
  input  logic signed [COORD_WIDTH-1:0] wr_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] wr_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] wr_min_z_i,
  input  logic signed [COORD_WIDTH-1:0] wr_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] wr_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] wr_max_z_i,
  input  logic                          nb_solid_i,
  input  logic signed [COORD_WIDTH-1:0] nb_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] nb_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] nb_min_z_i,
  input  logic signed [COORD_WIDTH-1:0] nb_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] nb_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] nb_max_z_i,
  output logic                          solid_o,
  output logic signed [COORD_WIDTH-1:0] min_x_o,
  output logic signed [COORD_WIDTH-1:0] min_y_o,
  output logic signed [COORD_WIDTH-1:0] min_z_o,
  output logic signed [COORD_WIDTH-1:0] max_x_o,
  output logic signed [COORD_WIDTH-1:0] max_y_o,
  output logic signed [COORD_WIDTH-1:0] max_z_o
);

  logic solid_q;
  logic signed [COORD_WIDTH-1:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      solid_q <= 1'b0;
    end else if (load_i) begin
      solid_q <= wr_solid_i;
    end else if (shift_i) begin
      solid_q <= nb_solid_i;
    end
  end

  // Bounds carry no reset; an entry is only read once its solid flag is set.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      min_x_q <= wr_min_x_i;
      min_y_q <= wr_min_y_i;
      min_z_q <= wr_min_z_i;
      max_x_q <= wr_max_x_i;
      max_y_q <= wr_max_y_i;
      max_z_q <= wr_max_z_i;
    end else if (shift_i) begin
      min_x_q <= nb_min_x_i;
      min_y_q <= nb_min_y_i;
      min_z_q <= nb_min_z_i;
      max_x_q <= nb_max_x_i;
      max_y_q <= nb_max_y_i;
      max_z_q <= nb_max_z_i;
    end
  end

  assign solid_o = solid_q;
  assign min_x_o = min_x_q;
  assign min_y_o = min_y_q;
  assign min_z_o = min_z_q;
  assign max_x_o = max_x_q;
  assign max_y_o = max_y_q;
  assign max_z_o = max_z_q;

endmodule

// File: rtl/aabb_sphere_pushout_resolver_core.sv
// Top level of the box push-out resolver: ring of box cells plus a two-stage
// evaluator. Depends on aspr_pkg and aspr_cell.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | command, box_index, a_*, b_*, radius, solid
//   out     | output    | out_valid_o/out_stall_i | out_x, out_y, out_z, overlap
//   cfg     | input     | cfg_we_i                | cfg_data_i (box_count)
//
// A write item or an unknown command is taken without leaving the idle state. A resolve or
// check item runs the states RUN, DRAIN and DONE: the box ring rotates once fully, one
// box reaching the head cell per cycle, then the evaluator pipeline finishes in DRAIN and
// the output register is loaded in DONE once it is free. The input is taken again once the
// state machine is back in IDLE.
// Reset clears the solid flags, box_count, the state machine and the output
// valid; box bounds are left as they are.
// The input is stalled while an item is in work; a stalled output holds its
// item, and the block can still take the next input item meanwhile. A finished
// result that finds the output register still full waits there, and the input
// stays stalled until the output item leaves.
module aabb_sphere_pushout_resolver_core #(
  parameter int unsigned MAX_BOXES   = aspr_pkg::MaxBoxesDef,
  parameter int unsigned COORD_WIDTH = aspr_pkg::CoordWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [aspr_pkg::CountWidth-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             command_i,
  input  logic [aspr_pkg::IndexWidth-1:0]        box_index_i,
  input  logic signed [COORD_WIDTH-1:0]          a_x_i,
  input  logic signed [COORD_WIDTH-1:0]          a_y_i,
  input  logic signed [COORD_WIDTH-1:0]          a_z_i,
  input  logic signed [COORD_WIDTH-1:0]          b_x_i,
  input  logic signed [COORD_WIDTH-1:0]          b_y_i,
  input  logic signed [COORD_WIDTH-1:0]          b_z_i,
  input  logic [aspr_pkg::RadiusWidth-1:0]       radius_i,
  input  logic                                   solid_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [COORD_WIDTH-1:0]          out_x_o,
  output logic signed [COORD_WIDTH-1:0]          out_y_o,
  output logic signed [COORD_WIDTH-1:0]          out_z_o,
  output logic                                   overlap_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  // Extended width for sums: wide enough for a coordinate plus the radius.
  localparam int unsigned EW  = ((CW > aspr_pkg::RadiusWidth) ? CW : aspr_pkg::RadiusWidth) + 2;
  localparam int unsigned NW  = $clog2(MAX_BOXES + 1);
  localparam int unsigned KW  = (NW > aspr_pkg::CountWidth) ? NW : aspr_pkg::CountWidth;
  localparam logic signed [EW-1:0] HiE = EW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] LoE = EW'(-(64'sd1 <<< (CW - 1)));
  localparam logic [KW-1:0] NMax  = KW'(MAX_BOXES);
  localparam logic [NW-1:0] NLast = NW'(MAX_BOXES - 1);
  localparam logic [NW-1:0] NFull = NW'(MAX_BOXES);

  function automatic logic signed [CW-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > HiE) r = HiE[CW-1:0];
    else if (v < LoE) r = LoE[CW-1:0];
    else r = v[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [EW-1:0] ext(input logic signed [CW-1:0] v);
    return EW'(v);
  endfunction

  aspr_pkg::state_e state_q, state_d;
  logic [KW-1:0]  count_q;
  logic [NW-1:0]  cnt_q;
  logic [KW-1:0]  n_q;
  logic           check_q;
  logic signed [EW-1:0] r_q;
  // For resolve p_* is the point; for check p_* is the cube minimum and h_* the maximum.
  logic signed [CW-1:0] px_q, py_q, pz_q, hx_q, hy_q, hz_q;
  logic           ov_q;
  logic           accept, start, shift, use_d;

  // Evaluator stage A registers.
  logic           a_use_q;
  logic signed [CW-1:0] alx_q, aly_q, alz_q, ahx_q, ahy_q, ahz_q;

  logic           out_valid_q;
  logic signed [CW-1:0] ox_q, oy_q, oz_q;
  logic           oov_q;

  // Ring of cells.
  logic                 c_solid [MAX_BOXES];
  logic signed [CW-1:0] c_minx [MAX_BOXES];
  logic signed [CW-1:0] c_miny [MAX_BOXES];
  logic signed [CW-1:0] c_minz [MAX_BOXES];
  logic signed [CW-1:0] c_maxx [MAX_BOXES];
  logic signed [CW-1:0] c_maxy [MAX_BOXES];
  logic signed [CW-1:0] c_maxz [MAX_BOXES];

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    localparam int unsigned Nb = (i + 1) % MAX_BOXES;
    logic load;
    assign load = accept && (aspr_pkg::cmd_e'(command_i) == aspr_pkg::CMD_WRITE) &&
                  (32'(box_index_i) == i);
    aspr_cell #(.COORD_WIDTH(CW)) u_cell (
      .clk_i, .rst_ni,
      .load_i(load), .shift_i(shift), .wr_solid_i(solid_i),
      .wr_min_x_i(a_x_i), .wr_min_y_i(a_y_i), .wr_min_z_i(a_z_i),
      .wr_max_x_i(b_x_i), .wr_max_y_i(b_y_i), .wr_max_z_i(b_z_i),
      .nb_solid_i(c_solid[Nb]),
      .nb_min_x_i(c_minx[Nb]), .nb_min_y_i(c_miny[Nb]), .nb_min_z_i(c_minz[Nb]),
      .nb_max_x_i(c_maxx[Nb]), .nb_max_y_i(c_maxy[Nb]), .nb_max_z_i(c_maxz[Nb]),
      .solid_o(c_solid[i]),
      .min_x_o(c_minx[i]), .min_y_o(c_miny[i]), .min_z_o(c_minz[i]),
      .max_x_o(c_maxx[i]), .max_y_o(c_maxy[i]), .max_z_o(c_maxz[i])
    );
  end

  // State machine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aspr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    shift      = 1'b0;
    start      = 1'b0;
    unique case (state_q)
      aspr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && ((aspr_pkg::cmd_e'(command_i) == aspr_pkg::CMD_RESOLVE) ||
                           (aspr_pkg::cmd_e'(command_i) == aspr_pkg::CMD_CHECK))) begin
          start   = 1'b1;
          state_d = aspr_pkg::ST_RUN;
        end
      end
      aspr_pkg::ST_RUN: begin
        shift = 1'b1;
        if (cnt_q == NLast) state_d = aspr_pkg::ST_DRAIN;
      end
      aspr_pkg::ST_DRAIN: begin
        state_d = aspr_pkg::ST_DONE;
      end
      aspr_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = aspr_pkg::ST_IDLE;
      end
      default: state_d = aspr_pkg::ST_IDLE;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;
  assign use_d  = (state_q == aspr_pkg::ST_RUN) && c_solid[0] && (KW'(cnt_q) < n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cnt_q       <= '0;
      a_use_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) count_q <= KW'(cfg_data_i);
      if (start) cnt_q <= '0;
      else if (shift) cnt_q <= cnt_q + 1'b1;
      a_use_q <= use_d;
      if (state_q == aspr_pkg::ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage A: fetch the head box, growing it by the radius for a resolve item.
  always_ff @(posedge clk_i) begin
    if (check_q) begin
      alx_q <= c_minx[0]; aly_q <= c_miny[0]; alz_q <= c_minz[0];
      ahx_q <= c_maxx[0]; ahy_q <= c_maxy[0]; ahz_q <= c_maxz[0];
    end else begin
      alx_q <= sat(ext(c_minx[0]) - r_q);
      aly_q <= sat(ext(c_miny[0]) - r_q);
      alz_q <= sat(ext(c_minz[0]) - r_q);
      ahx_q <= sat(ext(c_maxx[0]) + r_q);
      ahy_q <= sat(ext(c_maxy[0]) + r_q);
      ahz_q <= sat(ext(c_maxz[0]) + r_q);
    end
  end

  // Stage B: containment test and push to the nearest face, or overlap test.
  logic in_box, hit;
  logic signed [CW:0] d0, d1, d2, d3, d4, d5, dbest;
  logic [2:0] best;

  always_comb begin
    in_box = (px_q >= alx_q) && (px_q <= ahx_q) && (py_q >= aly_q) && (py_q <= ahy_q) &&
             (pz_q >= alz_q) && (pz_q <= ahz_q);
    hit    = (hx_q >= alx_q) && (px_q <= ahx_q) && (hy_q >= aly_q) && (py_q <= ahy_q) &&
             (hz_q >= alz_q) && (pz_q <= ahz_q);
    d0 = (CW+1)'(px_q) - (CW+1)'(alx_q);
    d1 = (CW+1)'(ahx_q) - (CW+1)'(px_q);
    d2 = (CW+1)'(py_q) - (CW+1)'(aly_q);
    d3 = (CW+1)'(ahy_q) - (CW+1)'(py_q);
    d4 = (CW+1)'(pz_q) - (CW+1)'(alz_q);
    d5 = (CW+1)'(ahz_q) - (CW+1)'(pz_q);
    // Strict compares keep the earlier face on a tie.
    best = 3'd0; dbest = d0;
    if (d1 < dbest) begin best = 3'd1; dbest = d1; end
    if (d2 < dbest) begin best = 3'd2; dbest = d2; end
    if (d3 < dbest) begin best = 3'd3; dbest = d3; end
    if (d4 < dbest) begin best = 3'd4; dbest = d4; end
    if (d5 < dbest) begin best = 3'd5; end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      check_q <= (aspr_pkg::cmd_e'(command_i) == aspr_pkg::CMD_CHECK);
      r_q     <= EW'({1'b0, radius_i});
      n_q     <= (KW'(count_q) > NMax) ? NMax : count_q;
      ov_q    <= 1'b0;
      if (aspr_pkg::cmd_e'(command_i) == aspr_pkg::CMD_CHECK) begin
        px_q <= sat(ext(a_x_i) - EW'({1'b0, radius_i}));
        py_q <= sat(ext(a_y_i) - EW'({1'b0, radius_i}));
        pz_q <= sat(ext(a_z_i) - EW'({1'b0, radius_i}));
        hx_q <= sat(ext(a_x_i) + EW'({1'b0, radius_i}));
        hy_q <= sat(ext(a_y_i) + EW'({1'b0, radius_i}));
        hz_q <= sat(ext(a_z_i) + EW'({1'b0, radius_i}));
      end else begin
        px_q <= sat(ext(a_x_i) + ext(b_x_i));
        py_q <= sat(ext(a_y_i) + ext(b_y_i));
        pz_q <= sat(ext(a_z_i) + ext(b_z_i));
      end
    end else if (a_use_q) begin
      if (check_q) begin
        if (hit) ov_q <= 1'b1;
      end else if (in_box) begin
        case (best)
          3'd0:    px_q <= alx_q;
          3'd1:    px_q <= ahx_q;
          3'd2:    py_q <= aly_q;
          3'd3:    py_q <= ahy_q;
          3'd4:    pz_q <= alz_q;
          default: pz_q <= ahz_q;
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (state_q == aspr_pkg::ST_DONE && (!out_valid_q || !out_stall_i)) begin
      ox_q  <= check_q ? '0 : px_q;
      oy_q  <= check_q ? '0 : py_q;
      oz_q  <= check_q ? '0 : pz_q;
      oov_q <= check_q ? ov_q : 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign overlap_o   = oov_q;

  // No input item is taken while a pass is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != aspr_pkg::ST_IDLE) |-> in_stall_o)
    else $error("input taken while an item is in work");

  // Stage B only sees a box fetched during a ring pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_use_q |-> $past(state_q == aspr_pkg::ST_RUN))
    else $error("evaluator used outside a box pass");

  // A resolve result never reports an overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overlap_o) |-> (out_x_o == '0 && out_y_o == '0 && out_z_o == '0))
    else $error("overlap flag on a resolve result");

  // A full pass has shifted the ring exactly once around, back to its home position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aspr_pkg::ST_DRAIN) |-> (cnt_q == NFull))
    else $error("ring not realigned after a pass");

endmodule

// File: bench/aspr_checker.sv
`timescale 1ns / 100ps
// Checker for the box push-out resolver: tracks the box table and box_count,
// predicts one result per resolve or check item and compares it with the block.
// Depends on aspr_pkg.
module aspr_checker #(
  parameter int unsigned CW = aspr_pkg::CoordWidthDef,
  parameter int unsigned NB = aspr_pkg::MaxBoxesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [aspr_pkg::CountWidth-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [aspr_pkg::IndexWidth-1:0]     box_index_i,
  input  logic signed [CW-1:0]                a_x_i,
  input  logic signed [CW-1:0]                a_y_i,
  input  logic signed [CW-1:0]                a_z_i,
  input  logic signed [CW-1:0]                b_x_i,
  input  logic signed [CW-1:0]                b_y_i,
  input  logic signed [CW-1:0]                b_z_i,
  input  logic [aspr_pkg::RadiusWidth-1:0]    radius_i,
  input  logic                                solid_i,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic signed [CW-1:0]                out_x_o,
  input  logic signed [CW-1:0]                out_y_o,
  input  logic signed [CW-1:0]                out_z_o,
  input  logic                                overlap_o,
  output int                                  fail_count,
  output int                                  pending
);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 ov;
  } position_t;

  localparam longint CoordHi = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint CoordLo = -(longint'(1) <<< (CW - 1));

  longint    lo_tab [3][NB];
  longint    hi_tab [3][NB];
  bit        solid_tab [NB];
  int        boxes_used;
  position_t expected_positions [$];

  function automatic longint clamp_coord(longint v);
    if (v > CoordHi) return CoordHi;
    if (v < CoordLo) return CoordLo;
    return v;
  endfunction

  function automatic int active_boxes();
    return (boxes_used > NB) ? NB : boxes_used;
  endfunction

  // Appends one predicted result at the tail of the queue.
  function automatic void queue_result(position_t p);
    expected_positions.insert(expected_positions.size(), p);
  endfunction

  // Push the moved point out of every grown solid box in use, in index order.
  function automatic position_t push_out(longint px, longint py, longint pz, longint r);
    longint    p [3];
    longint    lo [3];
    longint    hi [3];
    longint    gap [6];
    int        best;
    bit        in_box;
    position_t res;
    p[0] = px; p[1] = py; p[2] = pz;
    for (int i = 0; i < active_boxes(); i++) begin
      if (!solid_tab[i]) continue;
      in_box = 1'b1;
      for (int a = 0; a < 3; a++) begin
        lo[a] = clamp_coord(lo_tab[a][i] - r);
        hi[a] = clamp_coord(hi_tab[a][i] + r);
        if (p[a] < lo[a] || p[a] > hi[a]) in_box = 1'b0;
      end
      if (!in_box) continue;
      for (int a = 0; a < 3; a++) begin
        gap[2*a]   = p[a] - lo[a];
        gap[2*a+1] = hi[a] - p[a];
      end
      // Strict comparison keeps the earliest face on equal distances.
      best = 0;
      for (int f = 1; f < 6; f++) if (gap[f] < gap[best]) best = f;
      p[best/2] = (best % 2 == 1) ? hi[best/2] : lo[best/2];
    end
    res.x = p[0][CW-1:0]; res.y = p[1][CW-1:0]; res.z = p[2][CW-1:0];
    res.ov = 1'b0;
    return res;
  endfunction

  function automatic bit cube_hits(longint px, longint py, longint pz, longint r);
    longint p [3];
    bit     hit;
    p[0] = px; p[1] = py; p[2] = pz;
    for (int i = 0; i < active_boxes(); i++) begin
      if (!solid_tab[i]) continue;
      hit = 1'b1;
      for (int a = 0; a < 3; a++)
        if (clamp_coord(p[a] + r) < lo_tab[a][i] || clamp_coord(p[a] - r) > hi_tab[a][i])
          hit = 1'b0;
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    position_t want;
    position_t got;
    if (!rst_ni) begin
      foreach (solid_tab[i]) solid_tab[i] = 1'b0;
      boxes_used = 0;
      fail_count = 0;
      expected_positions.delete();
      pending = 0;
    end else begin
      if (cfg_we_i) boxes_used = cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        case (aspr_pkg::cmd_e'(command_i))
          aspr_pkg::CMD_WRITE: begin
            lo_tab[0][box_index_i] = a_x_i; lo_tab[1][box_index_i] = a_y_i;
            lo_tab[2][box_index_i] = a_z_i;
            hi_tab[0][box_index_i] = b_x_i; hi_tab[1][box_index_i] = b_y_i;
            hi_tab[2][box_index_i] = b_z_i;
            solid_tab[box_index_i] = solid_i;
          end
          aspr_pkg::CMD_RESOLVE: begin
            queue_result(push_out(
                clamp_coord(longint'(a_x_i) + longint'(b_x_i)),
                clamp_coord(longint'(a_y_i) + longint'(b_y_i)),
                clamp_coord(longint'(a_z_i) + longint'(b_z_i)),
                longint'(radius_i)));
          end
          aspr_pkg::CMD_CHECK: begin
            want = '0;
            want.ov = cube_hits(a_x_i, a_y_i, a_z_i, longint'(radius_i));
            queue_result(want);
          end
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        got = {out_x_o, out_y_o, out_z_o, overlap_o};
        if (expected_positions.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: x=%0d y=%0d z=%0d overlap=%0b",
                     got.x, got.y, got.z, got.ov);
        end else begin
          want = expected_positions.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result mismatch: expected x=%0d y=%0d z=%0d overlap=%0b, ",
                        "got x=%0d y=%0d z=%0d overlap=%0b"},
                       want.x, want.y, want.z, want.ov, got.x, got.y, got.z, got.ov);
          end
        end
      end
      pending = expected_positions.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the resolver testbench: clock, reset, item stimulus, output stalls and verdict.
// Depends on aspr_pkg, aspr_checker and aabb_sphere_pushout_resolver_core.
module tb_top;

  localparam int unsigned CW = aspr_pkg::CoordWidthDef;
  localparam int unsigned IW = aspr_pkg::IndexWidth;
  localparam int unsigned RW = aspr_pkg::RadiusWidth;
  localparam int unsigned KW = aspr_pkg::CountWidth;
  // This margin covers a resolve or check item still in flight after the last
  // expected result came out.
  localparam int DrainCycles = 80;
  localparam int IdleLimit   = 5000;
  localparam int HoldCycles  = 600;

  typedef struct {
    aspr_pkg::cmd_e       cmd;
    logic [IW-1:0]        idx;
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    logic [RW-1:0]        rad;
    logic                 sol;
  } cmd_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [KW-1:0]          cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             command = aspr_pkg::CMD_NONE;
  logic [IW-1:0]          box_index = '0;
  logic signed [CW-1:0]   a_x = '0, a_y = '0, a_z = '0;
  logic signed [CW-1:0]   b_x = '0, b_y = '0, b_z = '0;
  logic [RW-1:0]          radius = '0;
  logic                   solid = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [CW-1:0]   out_x, out_y, out_z;
  logic                   overlap;
  int                     fail_count;
  int                     pending;

  // Idle percentages of the sender and receiver for the current phase.
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  bit held      = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  aabb_sphere_pushout_resolver_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .box_index_i(box_index),
    .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z),
    .radius_i(radius), .solid_i(solid),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z), .overlap_o(overlap)
  );

  aspr_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .box_index_i(box_index),
    .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z),
    .radius_i(radius), .solid_i(solid),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z), .overlap_o(overlap),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random stalls per phase, or one long hold-off on request so that
  // the block fills up and stalls its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (HoldCycles) begin
          out_stall <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and returns right after the edge that accepted it. Valid is
  // left high; the caller lowers it when no item follows at once.
  task automatic send_item(cmd_item_t it);
    bit stalled;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command <= it.cmd; box_index <= it.idx;
    a_x <= it.ax; a_y <= it.ay; a_z <= it.az;
    b_x <= it.bx; b_y <= it.by; b_z <= it.bz;
    radius <= it.rad; solid <= it.sol;
    forever begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
      if (!stalled) break;
    end
  endtask

  // Waits until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // The register is only written while the block is idle.
  task automatic set_box_count(int value);
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= value[KW-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly coordinates near the origin, where boxes and points meet; now and
  // then a full-range value to reach saturation and every bit.
  function automatic logic signed [CW-1:0] pick_coord(int span);
    if ($urandom_range(99) < 8) return CW'($urandom);
    return CW'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic cmd_item_t make_item(aspr_pkg::cmd_e c, int idx, int ax, int ay,
                                          int az, int bx, int by, int bz, int rad,
                                          bit sol);
    cmd_item_t it;
    it.cmd = c; it.idx = idx[IW-1:0];
    it.ax = ax[CW-1:0]; it.ay = ay[CW-1:0]; it.az = az[CW-1:0];
    it.bx = bx[CW-1:0]; it.by = by[CW-1:0]; it.bz = bz[CW-1:0];
    it.rad = rad[RW-1:0]; it.sol = sol;
    return it;
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int        sel;
    sel = $urandom_range(99);
    it.idx = IW'($urandom); it.sol = ($urandom_range(99) < 70);
    it.rad = ($urandom_range(99) < 20) ? RW'($urandom) : RW'($urandom_range(1500));
    it.ax = pick_coord(4000); it.ay = pick_coord(4000); it.az = pick_coord(4000);
    if (sel < 25) begin
      it.cmd = aspr_pkg::CMD_WRITE;
      // Usually a proper box; sometimes inverted or arbitrary bounds.
      if ($urandom_range(99) < 10) begin
        it.bx = pick_coord(4000); it.by = pick_coord(4000); it.bz = pick_coord(4000);
      end else begin
        it.bx = CW'(it.ax + $urandom_range(3000));
        it.by = CW'(it.ay + $urandom_range(3000));
        it.bz = CW'(it.az + $urandom_range(3000));
      end
    end else begin
      it.cmd = (sel < 60) ? aspr_pkg::CMD_RESOLVE :
               (sel < 95) ? aspr_pkg::CMD_CHECK : aspr_pkg::CMD_NONE;
      it.bx = pick_coord(500); it.by = pick_coord(500); it.bz = pick_coord(500);
    end
    return it;
  endfunction

  localparam int CHi = (1 << (CW - 1)) - 1;
  localparam int CLo = -(1 << (CW - 1));

  initial begin
    int counts [8] = '{64, 1, 127, 0, 37, 64, 100, 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Give every entry defined bounds first, all non-solid.
    for (int i = 0; i < 64; i++)
      send_item(make_item(aspr_pkg::CMD_WRITE, i, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, 0, 1'b0));

    // No boxes in use: the moved point only saturates, checks find nothing.
    set_box_count(0);
    send_item(make_item(aspr_pkg::CMD_RESOLVE, 0, CHi, CHi, CHi, CHi, CHi, CHi, 0, 0));
    send_item(make_item(aspr_pkg::CMD_RESOLVE, 0, CLo, CLo, CLo, CLo, CLo, CLo,
                        16'hFFFF, 0));
    send_item(make_item(aspr_pkg::CMD_CHECK, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0));

    // A count above the table size acts as the full table.
    set_box_count(127);
    send_item(make_item(aspr_pkg::CMD_WRITE, 0, -1000, -1000, -1000, 1000, 1000, 1000,
                        0, 1));
    send_item(make_item(aspr_pkg::CMD_WRITE, 63, CHi - 600, CHi - 600, CHi - 600,
                        CHi, CHi, CHi, 0, 1));
    // Inverted box: minimum above maximum.
    send_item(make_item(aspr_pkg::CMD_WRITE, 5, 500, 500, 500, -500, -500, -500, 0, 1));
    // Point at the center: every face is as far, so the minus-x face wins.
    send_item(make_item(aspr_pkg::CMD_RESOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Point exactly on a bound still counts as within the box.
    send_item(make_item(aspr_pkg::CMD_RESOLVE, 0, 990, 0, 0, 10, 0, 0, 0, 0));
    send_item(make_item(aspr_pkg::CMD_RESOLVE, 0, 200, -300, 900, 0, 0, 0, 64, 0));
    // Grown bounds saturate at the top of the range.
    send_item(make_item(aspr_pkg::CMD_RESOLVE, 0, CHi - 100, CHi - 10, CHi - 300,
                        0, 0, 0, 16'hFFFF, 0));
    send_item(make_item(aspr_pkg::CMD_CHECK, 0, CHi, CHi, CHi, 0, 0, 0, 16'hFFFF, 0));
    send_item(make_item(aspr_pkg::CMD_CHECK, 0, CLo, CLo, CLo, 0, 0, 0, 16'hFFFF, 0));
    send_item(make_item(aspr_pkg::CMD_CHECK, 0, 1000 + 256, 0, 0, 0, 0, 0, 256, 0));
    send_item(make_item(aspr_pkg::CMD_CHECK, 0, 1000 + 257, 0, 0, 0, 0, 0, 256, 0));
    send_item(make_item(aspr_pkg::CMD_NONE, 63, -1, -1, -1, -1, -1, -1, 16'hFFFF, 1));
    send_item(make_item(aspr_pkg::CMD_WRITE, 5, 0, 0, 0, 0, 0, 0, 0, 0));

    // Random part: eight segments cycling through the idling phases, with the box
    // count set anew before each.
    for (int seg = 0; seg < 8; seg++) begin
      set_box_count((seg == 7) ? int'($urandom_range(127)) : counts[seg]);
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      if (seg == 2) hold_req = 1'b1;
      for (int n = 0; n < 210; n++) begin
        if (seg == 5 && n == 100) drain_results();
        send_item(random_item());
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
